### hw/rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg - Montgomery constant generator shared definitions
// Item record carried down the cell chain, cell modes and modular add helper.
// ----------------------------------------------------------------------------
package mcg_pkg;

   localparam logic [63:0] DEFAULT_PRIME = 64'hFFFF_FFFF_0000_0001;
   localparam int NEWTON_STEPS = 5;
   localparam int WORD_BITS    = 64;

   // mod cell kinds
   localparam logic [1:0] MODE_DOUBLE_R   = 2'd0;
   localparam logic [1:0] MODE_DOUBLE_ACC = 2'd1;
   localparam logic [1:0] MODE_ADD_R      = 2'd2;

   // one item in flight
   typedef struct packed {
      logic [63:0] q;    // modulus in use
      logic [63:0] x;    // Newton estimate of q^-1
      logic [63:0] r;    // 2^64 mod q, built by doubling
      logic [63:0] acc;  // r*r mod q accumulator
   } item_type;

   // (a + b) mod m for a, b < m
   function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] m);
      logic [63:0] gap;
      gap = m - b;
      if (a >= gap) begin
         return a - gap;
      end
      return a + b;
   endfunction

endpackage

### hw/rtl/mcg_newton_cell.sv
// ----------------------------------------------------------------------------
// mcg_newton_cell - one Newton step x <- x * (2 - q*x) mod 2^64
// Four register stages: q*x partials, t = 2 - q*x, x*t partials, sum.
// ----------------------------------------------------------------------------
module mcg_newton_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  mcg_pkg::item_type in_item,
   output logic              out_valid,
   output mcg_pkg::item_type out_item
);

   logic [3:0]        valid_ff;
   mcg_pkg::item_type item_a_ff, item_b_ff, item_c_ff, item_d_ff;
   mcg_pkg::item_type item_d_in;
   logic [63:0]       pa0_ff, pc0_ff, t_ff;
   logic [31:0]       pa1_ff, pa2_ff, pc1_ff, pc2_ff;
   logic [63:0]       t_in, x_in;

   // low 64 bits of the products from 32x32 partials
   assign t_in = 64'd2 - (pa0_ff + {pa1_ff + pa2_ff, 32'd0});
   assign x_in = pc0_ff + {pc1_ff + pc2_ff, 32'd0};

   // new estimate replaces x
   always_comb begin
      item_d_in   = item_c_ff;
      item_d_in.x = x_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // q*x partials
         item_a_ff <= in_item;
         pa0_ff    <= 64'(in_item.q[31:0]) * 64'(in_item.x[31:0]);
         pa1_ff    <= 32'(in_item.q[31:0] * in_item.x[63:32]);
         pa2_ff    <= 32'(in_item.q[63:32] * in_item.x[31:0]);
         // t = 2 - q*x
         item_b_ff <= item_a_ff;
         t_ff      <= t_in;
         // x*t partials
         item_c_ff <= item_b_ff;
         pc0_ff    <= 64'(item_b_ff.x[31:0]) * 64'(t_ff[31:0]);
         pc1_ff    <= 32'(item_b_ff.x[31:0] * t_ff[63:32]);
         pc2_ff    <= 32'(item_b_ff.x[63:32] * t_ff[31:0]);
         // new estimate
         item_d_ff <= item_d_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_item  = item_d_ff;

endmodule

### hw/rtl/mcg_mod_cell.sv
// ----------------------------------------------------------------------------
// mcg_mod_cell - one modular add step of the R^2 chain
// Doubles r, doubles acc, or adds r to acc when a fixed bit of r is set.
// ----------------------------------------------------------------------------
module mcg_mod_cell #(
   parameter logic [1:0] MODE = 2'd0,
   parameter int         BIT  = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  mcg_pkg::item_type in_item,
   output logic              out_valid,
   output mcg_pkg::item_type out_item
);

   logic              valid_ff;
   mcg_pkg::item_type item_ff, item_in;

   always_comb begin
      item_in = in_item;
      case (MODE)
         mcg_pkg::MODE_DOUBLE_R:
            item_in.r = mcg_pkg::add_mod(in_item.r, in_item.r, in_item.q);
         mcg_pkg::MODE_DOUBLE_ACC:
            item_in.acc = mcg_pkg::add_mod(in_item.acc, in_item.acc, in_item.q);
         mcg_pkg::MODE_ADD_R:
            item_in.acc = mcg_pkg::add_mod(in_item.acc,
                                           in_item.r[BIT] ? in_item.r : 64'd0, in_item.q);
         default:
            item_in = in_item;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### hw/rtl/montgomery_constant_generator.sv
// Pipeline: input register, 5 Newton cells of 4 stages, 192 mod cells.
// Throughput: one modulus per cycle; the whole chain advances together and
// holds while the result beat waits for rsp_tready.
// Reset: synchronous, clears only the valid bits of the chain.
// ----------------------------------------------------------------------------
// montgomery_constant_generator - Montgomery constants for R = 2^64
// Returns q, -q^-1 mod 2^64 and 2^128 mod q; zero selects the default prime.
// ----------------------------------------------------------------------------
module montgomery_constant_generator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // [63:0] modulus
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata    // [63:0] modulus_used, [127:64] neg_inverse,
                                     // [191:128] r_squared
);

   localparam int NMOD = 3 * mcg_pkg::WORD_BITS;

   logic              en;
   logic              in_valid_ff;
   mcg_pkg::item_type in_item_ff;
   logic [63:0]       q_sel;

   logic              nv [mcg_pkg::NEWTON_STEPS+1];
   mcg_pkg::item_type ni [mcg_pkg::NEWTON_STEPS+1];
   logic              mv [NMOD+1];
   mcg_pkg::item_type mi [NMOD+1];

   // whole chain stalls when the result beat is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign q_sel = (req_tdata == 64'd0) ? mcg_pkg::DEFAULT_PRIME : req_tdata;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_item_ff.q   <= q_sel;
         in_item_ff.x   <= q_sel;
         in_item_ff.r   <= (q_sel == 64'd1) ? 64'd0 : 64'd1;
         in_item_ff.acc <= 64'd0;
      end
   end

   assign nv[0] = in_valid_ff;
   assign ni[0] = in_item_ff;

   // Newton cells
   for (genvar i = 0; i < mcg_pkg::NEWTON_STEPS; i++) begin : g_newton
      mcg_newton_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (nv[i]),
         .in_item  (ni[i]),
         .out_valid(nv[i+1]),
         .out_item (ni[i+1])
      );
   end

   assign mv[0] = nv[mcg_pkg::NEWTON_STEPS];
   assign mi[0] = ni[mcg_pkg::NEWTON_STEPS];

   // mod cells: 64 doublings of r, then double-and-add of r*r, msb first
   for (genvar k = 0; k < NMOD; k++) begin : g_mod
      localparam int J = k - mcg_pkg::WORD_BITS;
      localparam logic [1:0] M = (k < mcg_pkg::WORD_BITS) ? mcg_pkg::MODE_DOUBLE_R :
                                 ((J % 2) == 0) ? mcg_pkg::MODE_DOUBLE_ACC :
                                 mcg_pkg::MODE_ADD_R;
      localparam int B = (k < mcg_pkg::WORD_BITS) ? 0 : (mcg_pkg::WORD_BITS - 1) - (J / 2);
      mcg_mod_cell #(.MODE(M), .BIT(B)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (mv[k]),
         .in_item  (mi[k]),
         .out_valid(mv[k+1]),
         .out_item (mi[k+1])
      );
   end

   // result beat straight from the last cell register
   assign rsp_tvalid = mv[NMOD];
   assign rsp_tdata  = {mi[NMOD].acc, 64'd0 - mi[NMOD].x, mi[NMOD].q};

endmodule
